/* hdl/toy_byte_cpu_step_macros.svh */
// Assertion macros used by the checker file of the byte machine.
`ifndef TOY_BYTE_CPU_STEP_MACROS_SVH
`define TOY_BYTE_CPU_STEP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBCS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TBCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tbcs_pkg.sv */
// Types, constants and the microcode store of the byte machine.
package tbcs_pkg;

  localparam int REG_COUNT = 16;
  localparam int REG_AW    = 4;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_EXEC  = 2'd1,
    KIND_RDMEM = 2'd2,
    KIND_RDREG = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  address;
    logic [7:0]  data;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [7:0]  program_counter;
    logic [15:0] instruction;
    logic        halted;
    logic        pc_fault;
  } out_word_t;

  // Opcodes (top nibble of the instruction word).
  localparam logic [3:0] OP_LOAD  = 4'h1;
  localparam logic [3:0] OP_LDI   = 4'h2;
  localparam logic [3:0] OP_STORE = 4'h3;
  localparam logic [3:0] OP_MOVE  = 4'h4;
  localparam logic [3:0] OP_ADD   = 4'h5;
  localparam logic [3:0] OP_NOP   = 4'h6;
  localparam logic [3:0] OP_OR    = 4'h7;
  localparam logic [3:0] OP_AND   = 4'h8;
  localparam logic [3:0] OP_XOR   = 4'h9;
  localparam logic [3:0] OP_ROR   = 4'hA;
  localparam logic [3:0] OP_JMP   = 4'hB;
  localparam logic [3:0] OP_BRGT  = 4'hD;

  // Control word fields.
  typedef enum logic [1:0] {MRA_PC, MRA_PC1, MRA_XY, MRA_ADDR} mra_t;
  typedef enum logic [1:0] {MW_NONE, MW_DATA, MW_REG} mw_t;
  typedef enum logic [2:0] {RRA_R, RRA_S, RRA_T, RRA_ZERO, RRA_ADDR} rra_t;
  typedef enum logic [1:0] {ML_NONE, ML_IRH, ML_IRL, ML_A} mlat_t;
  typedef enum logic [1:0] {RL_NONE, RL_A, RL_B} rlat_t;
  typedef enum logic [1:0] {RW_NONE, RW_R, RW_T} rw_t;
  typedef enum logic [1:0] {ALU_PASS, ALU_IMM, ALU_BIN, ALU_ROR} alu_t;
  typedef enum logic [1:0] {PC_KEEP, PC_INC2, PC_XY, PC_A} pcop_t;
  typedef enum logic [1:0] {FL_NONE, FL_HALT, FL_FAULT} flag_t;
  typedef enum logic [2:0] {SQ_NEXT, SQ_JUMP, SQ_DISPATCH, SQ_BRGT, SQ_DONE} seq_t;

  typedef logic [5:0] upc_t;

  // Microprogram addresses.
  localparam upc_t U_IDLE = 6'd0;
  localparam upc_t U_WR   = 6'd1;
  localparam upc_t U_RM0  = 6'd2;
  localparam upc_t U_RM1  = 6'd3;
  localparam upc_t U_RM2  = 6'd4;
  localparam upc_t U_RR0  = 6'd5;
  localparam upc_t U_RR1  = 6'd6;
  localparam upc_t U_RR2  = 6'd7;
  localparam upc_t U_XNOP = 6'd8;
  localparam upc_t U_XFLT = 6'd9;
  localparam upc_t U_F0   = 6'd10;
  localparam upc_t U_F1   = 6'd11;
  localparam upc_t U_F2   = 6'd12;
  localparam upc_t U_F3   = 6'd13;
  localparam upc_t U_LD0  = 6'd14;
  localparam upc_t U_LD1  = 6'd15;
  localparam upc_t U_LD2  = 6'd16;
  localparam upc_t U_LDI  = 6'd17;
  localparam upc_t U_ST0  = 6'd18;
  localparam upc_t U_ST1  = 6'd19;
  localparam upc_t U_MV0  = 6'd20;
  localparam upc_t U_MV1  = 6'd21;
  localparam upc_t U_MV2  = 6'd22;
  localparam upc_t U_AL0  = 6'd23;
  localparam upc_t U_AL1  = 6'd24;
  localparam upc_t U_AL2  = 6'd25;
  localparam upc_t U_AL3  = 6'd26;
  localparam upc_t U_RO0  = 6'd27;
  localparam upc_t U_RO1  = 6'd28;
  localparam upc_t U_JP0  = 6'd29;
  localparam upc_t U_JP1  = 6'd30;
  localparam upc_t U_BR0  = 6'd31;
  localparam upc_t U_BR1  = 6'd32;
  localparam upc_t U_BR2  = 6'd33;
  localparam upc_t U_TAIL = 6'd34;
  localparam upc_t U_BRT  = 6'd35;
  localparam upc_t U_HLT  = 6'd36;

  typedef struct packed {
    mra_t  mra;
    mw_t   mw;
    rra_t  rra;
    mlat_t mlat;
    rlat_t rlat;
    rw_t   rw;
    alu_t  alu;
    pcop_t pcop;
    flag_t flag;
    seq_t  seq;
    logic  out_rd;
    logic  out_ir;
    upc_t  target;
  } uword_t;

  localparam uword_t UW_NOP = '{
    mra: MRA_PC, mw: MW_NONE, rra: RRA_R, mlat: ML_NONE, rlat: RL_NONE,
    rw: RW_NONE, alu: ALU_PASS, pcop: PC_KEEP, flag: FL_NONE, seq: SQ_NEXT,
    out_rd: 1'b0, out_ir: 1'b0, target: U_IDLE
  };

  // Microcode store. A read issued in one step is latched in the next.
  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    w = UW_NOP;
    unique case (a)
      U_WR:   begin w.mw = MW_DATA; w.seq = SQ_DONE; end
      U_RM0:  begin w.mra = MRA_ADDR; end
      U_RM1:  begin w.mlat = ML_A; end
      U_RM2:  begin w.seq = SQ_DONE; w.out_rd = 1'b1; end
      U_RR0:  begin w.rra = RRA_ADDR; end
      U_RR1:  begin w.rlat = RL_A; end
      U_RR2:  begin w.seq = SQ_DONE; w.out_rd = 1'b1; end
      U_XNOP: begin w.seq = SQ_DONE; end
      U_XFLT: begin w.flag = FL_FAULT; w.seq = SQ_DONE; end
      U_F0:   begin w.mra = MRA_PC; end
      U_F1:   begin w.mlat = ML_IRH; w.mra = MRA_PC1; end
      U_F2:   begin w.mlat = ML_IRL; end
      U_F3:   begin w.rra = RRA_R; w.seq = SQ_DISPATCH; end
      U_LD0:  begin w.mra = MRA_XY; end
      U_LD1:  begin w.mlat = ML_A; end
      U_LD2:  begin w.rw = RW_R; w.alu = ALU_PASS; w.seq = SQ_JUMP; w.target = U_TAIL; end
      U_LDI:  begin w.rw = RW_R; w.alu = ALU_IMM; w.seq = SQ_JUMP; w.target = U_TAIL; end
      U_ST0:  begin w.rlat = RL_A; end
      U_ST1:  begin w.mw = MW_REG; w.seq = SQ_JUMP; w.target = U_TAIL; end
      U_MV0:  begin w.rra = RRA_S; end
      U_MV1:  begin w.rlat = RL_A; end
      U_MV2:  begin w.rw = RW_T; w.alu = ALU_PASS; w.seq = SQ_JUMP; w.target = U_TAIL; end
      U_AL0:  begin w.rra = RRA_S; end
      U_AL1:  begin w.rlat = RL_A; w.rra = RRA_T; end
      U_AL2:  begin w.rlat = RL_B; end
      U_AL3:  begin w.rw = RW_R; w.alu = ALU_BIN; w.seq = SQ_JUMP; w.target = U_TAIL; end
      U_RO0:  begin w.rlat = RL_A; end
      U_RO1:  begin w.rw = RW_R; w.alu = ALU_ROR; w.seq = SQ_JUMP; w.target = U_TAIL; end
      U_JP0:  begin w.rlat = RL_A; end
      U_JP1:  begin w.pcop = PC_A; w.seq = SQ_DONE; w.out_ir = 1'b1; end
      U_BR0:  begin w.rlat = RL_A; w.rra = RRA_ZERO; end
      U_BR1:  begin w.rlat = RL_B; end
      U_BR2:  begin w.seq = SQ_BRGT; w.target = U_BRT; end
      U_TAIL: begin w.pcop = PC_INC2; w.seq = SQ_DONE; w.out_ir = 1'b1; end
      U_BRT:  begin w.pcop = PC_XY; w.seq = SQ_DONE; w.out_ir = 1'b1; end
      U_HLT:  begin w.flag = FL_HALT; w.seq = SQ_JUMP; w.target = U_TAIL; end
      default: w = UW_NOP;
    endcase
    return w;
  endfunction

  // Entry point of the routine for each opcode.
  function automatic upc_t dispatch(input logic [3:0] op);
    upc_t u;
    unique case (op)
      OP_LOAD:  u = U_LD0;
      OP_LDI:   u = U_LDI;
      OP_STORE: u = U_ST0;
      OP_MOVE:  u = U_MV0;
      OP_ADD, OP_OR, OP_AND, OP_XOR: u = U_AL0;
      OP_NOP:   u = U_TAIL;
      OP_ROR:   u = U_RO0;
      OP_JMP:   u = U_JP0;
      OP_BRGT:  u = U_BR0;
      default:  u = U_HLT;
    endcase
    return u;
  endfunction

endpackage

/* hdl/toy_byte_cpu_step.sv */
// Top level of the microcoded byte machine: sequencer, datapath and stores.
// The result strobe is registered and rises in the cycle after an item's last step.
// Steps per item: memory write 1, memory or register read 3, execute while halted
// or off the end of memory 1, executed instruction 5 to 9 (ALU ops take 9).
// No new item is taken while busy; fetch and operand reads go one at a time
// through the single read ports of the memory and the register file.
// Reset (synchronous, active low) zeroes pc, flags and all valid bits at once.
module toy_byte_cpu_step #(
  parameter int MEM_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tbcs_pkg::in_word_t   in_word,
  output logic                 out_valid,
  output tbcs_pkg::out_word_t  out_word
);
  import tbcs_pkg::*;

  localparam int         MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [8:0] MEM_LIMIT = 9'(MEM_DEPTH);

  // Sequencer state and the control word of the current step.
  upc_t   upc_r, upc_nxt;
  uword_t uw;

  // Architectural state; memory and register contents live in the RAMs, and an
  // entry that was never written since reset reads as zero via its valid bit.
  logic [7:0]           pc_r, pc_nxt;
  logic                 halt_r, halt_nxt;
  logic                 fault_r, fault_nxt;
  logic [MEM_DEPTH-1:0] mem_vld_r, mem_vld_nxt;
  logic [REG_COUNT-1:0] reg_vld_r, reg_vld_nxt;

  // Working registers of the datapath.
  in_word_t    in_r;
  logic [15:0] ir_r, ir_nxt;
  logic [7:0]  a_r, a_nxt;
  logic [7:0]  b_r, b_nxt;
  logic        mvld_q_r, mvld_q_nxt;
  logic        rvld_q_r, rvld_q_nxt;

  // Result register.
  out_word_t out_r, out_nxt;
  logic      out_valid_r;

  logic              accept;
  logic              done;
  logic [7:0]        xy;
  logic [3:0]        opc;
  logic [8:0]        mra9;
  logic [MEM_AW-1:0] mra_idx;
  logic              mrd_ok;
  logic [7:0]        mwa;
  logic [MEM_AW-1:0] mwa_idx;
  logic [7:0]        mwd;
  logic              mem_we;
  logic [7:0]        mem_rdata;
  logic [7:0]        mem_val;
  logic [REG_AW-1:0] rra;
  logic [REG_AW-1:0] rwa;
  logic              reg_we;
  logic [7:0]        reg_rdata;
  logic [7:0]        reg_val;
  logic [7:0]        alu;
  logic [8:0]        inc9;
  logic              gt;

  assign uw     = ucode(upc_r);
  assign busy   = (upc_r != U_IDLE);
  assign accept = start && !busy;
  assign done   = busy && (uw.seq == SQ_DONE);
  assign xy     = ir_r[7:0];
  assign opc    = ir_r[15:12];
  assign gt     = $signed(a_r) > $signed(b_r);
  assign inc9   = {1'b0, pc_r} + 9'd2;

  // Memory read port. The second fetch byte may sit one past the last address.
  always_comb begin
    unique case (uw.mra)
      MRA_PC:   mra9 = {1'b0, pc_r};
      MRA_PC1:  mra9 = {1'b0, pc_r} + 9'd1;
      MRA_XY:   mra9 = {1'b0, xy};
      MRA_ADDR: mra9 = {1'b0, in_r.address};
      default:  mra9 = {1'b0, pc_r};
    endcase
  end

  assign mrd_ok     = (mra9 < MEM_LIMIT);
  assign mra_idx    = mra9[MEM_AW-1:0];
  assign mvld_q_nxt = mrd_ok ? mem_vld_r[mra_idx] : 1'b0;
  assign mem_val    = mvld_q_r ? mem_rdata : 8'd0;

  // Memory write port: a host write or a store instruction. Out-of-range
  // addresses are dropped.
  assign mwa     = (uw.mw == MW_DATA) ? in_r.address : xy;
  assign mwd     = (uw.mw == MW_DATA) ? in_r.data : a_r;
  assign mwa_idx = mwa[MEM_AW-1:0];
  assign mem_we  = (uw.mw != MW_NONE) && ({1'b0, mwa} < MEM_LIMIT);

  tbcs_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mwa_idx),
    .wdata (mwd),
    .raddr (mra_idx),
    .rdata (mem_rdata)
  );

  // Register file read and write ports.
  always_comb begin
    unique case (uw.rra)
      RRA_R:    rra = ir_r[11:8];
      RRA_S:    rra = ir_r[7:4];
      RRA_T:    rra = ir_r[3:0];
      RRA_ZERO: rra = '0;
      RRA_ADDR: rra = in_r.address[REG_AW-1:0];
      default:  rra = '0;
    endcase
  end

  assign rvld_q_nxt = reg_vld_r[rra];
  assign reg_val    = rvld_q_r ? reg_rdata : 8'd0;
  assign rwa        = (uw.rw == RW_T) ? ir_r[3:0] : ir_r[11:8];
  assign reg_we     = (uw.rw != RW_NONE);

  // ALU: binary ops are picked by the opcode; rotate uses the low three bits of t.
  always_comb begin
    unique case (uw.alu)
      ALU_PASS: alu = a_r;
      ALU_IMM:  alu = xy;
      ALU_ROR:  alu = 8'({a_r, a_r} >> ir_r[2:0]);
      ALU_BIN: begin
        unique case (opc)
          OP_OR:   alu = a_r | b_r;
          OP_AND:  alu = a_r & b_r;
          OP_XOR:  alu = a_r ^ b_r;
          default: alu = a_r + b_r;
        endcase
      end
      default:  alu = a_r;
    endcase
  end

  tbcs_ram #(
    .WIDTH (8),
    .DEPTH (REG_COUNT)
  ) u_regs (
    .clk   (clk),
    .we    (reg_we),
    .waddr (rwa),
    .wdata (alu),
    .raddr (rra),
    .rdata (reg_rdata)
  );

  // Datapath next state.
  always_comb begin
    ir_nxt      = ir_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    pc_nxt      = pc_r;
    halt_nxt    = halt_r;
    fault_nxt   = fault_r;
    mem_vld_nxt = mem_vld_r;
    reg_vld_nxt = reg_vld_r;

    unique case (uw.mlat)
      ML_IRH:  ir_nxt[15:8] = mem_val;
      ML_IRL:  ir_nxt[7:0]  = mem_val;
      ML_A:    a_nxt        = mem_val;
      default: ;
    endcase

    unique case (uw.rlat)
      RL_A:    a_nxt = reg_val;
      RL_B:    b_nxt = reg_val;
      default: ;
    endcase

    if (mem_we) begin
      mem_vld_nxt[mwa_idx] = 1'b1;
    end
    if (reg_we) begin
      reg_vld_nxt[rwa] = 1'b1;
    end

    unique case (uw.flag)
      FL_HALT:  halt_nxt = 1'b1;
      FL_FAULT: begin
        halt_nxt  = 1'b1;
        fault_nxt = 1'b1;
      end
      default: ;
    endcase

    // Falling through past the last address halts with a fault; jumps never do.
    unique case (uw.pcop)
      PC_INC2: begin
        pc_nxt = inc9[7:0];
        if (inc9 >= MEM_LIMIT) begin
          halt_nxt  = 1'b1;
          fault_nxt = 1'b1;
        end
      end
      PC_XY:   pc_nxt = xy;
      PC_A:    pc_nxt = a_r;
      default: ;
    endcase
  end

  // Sequencer: the idle step dispatches on the item kind, every other step
  // follows its control word.
  always_comb begin
    upc_nxt = upc_r;
    if (!busy) begin
      if (accept) begin
        unique case (in_word.kind)
          KIND_WRITE: upc_nxt = U_WR;
          KIND_RDMEM: upc_nxt = U_RM0;
          KIND_RDREG: upc_nxt = U_RR0;
          KIND_EXEC: begin
            if (halt_r) begin
              upc_nxt = U_XNOP;
            end else if ({1'b0, pc_r} >= MEM_LIMIT) begin
              upc_nxt = U_XFLT;
            end else begin
              upc_nxt = U_F0;
            end
          end
          default:    upc_nxt = U_IDLE;
        endcase
      end
    end else begin
      unique case (uw.seq)
        SQ_NEXT:     upc_nxt = upc_r + 6'd1;
        SQ_JUMP:     upc_nxt = uw.target;
        SQ_DISPATCH: upc_nxt = dispatch(opc);
        SQ_BRGT:     upc_nxt = gt ? uw.target : upc_r + 6'd1;
        SQ_DONE:     upc_nxt = U_IDLE;
        default:     upc_nxt = U_IDLE;
      endcase
    end
  end

  // The result word carries the state as it stands after the final step.
  always_comb begin
    out_nxt                 = out_r;
    if (done) begin
      out_nxt.read_data       = uw.out_rd ? a_r : 8'd0;
      out_nxt.program_counter = pc_nxt;
      out_nxt.instruction     = uw.out_ir ? ir_r : 16'd0;
      out_nxt.halted          = halt_nxt;
      out_nxt.pc_fault        = fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= U_IDLE;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      fault_r     <= 1'b0;
      mem_vld_r   <= '0;
      reg_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      pc_r        <= pc_nxt;
      halt_r      <= halt_nxt;
      fault_r     <= fault_nxt;
      mem_vld_r   <= mem_vld_nxt;
      reg_vld_r   <= reg_vld_nxt;
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_word;
    end
    ir_r     <= ir_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    mvld_q_r <= mvld_q_nxt;
    rvld_q_r <= rvld_q_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

/* hdl/tbcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tbcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* hdl/tbcs_checker.sv */
// Port-level checker for the byte machine and its bind to the top level.
`include "toy_byte_cpu_step_macros.svh"

module tbcs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input tbcs_pkg::out_word_t out_word
);
  import tbcs_pkg::*;

  `TBCS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `TBCS_ASSERT_NEXT(a_strobe_pulse, out_valid, !out_valid, "result strobe longer than one cycle")
  `TBCS_ASSERT_SAME(a_strobe_idle, out_valid, !busy, "result shown while still busy")
  `TBCS_ASSERT_SAME(a_fault_halts, out_valid && out_word.pc_fault, out_word.halted, "fault without halt")

endmodule

bind toy_byte_cpu_step tbcs_checker u_tbcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);

/* tb/testbench.sv */
// Self-checking testbench for the toy_byte_cpu_step byte machine.
`timescale 1ns / 100ps

module testbench;
  import tbcs_pkg::*;

  localparam int MEM_DEPTH     = 256;
  localparam int ITEM_TARGET   = 1650;
  // Straight-line code starts at or below this address, so that a batch of
  // instructions never reaches the data area or runs off the end of memory.
  localparam int PC_SAFE       = 200;
  // Stores only go to the data area at the top of memory, above any code.
  localparam int DATA_BASE     = 224;
  // Longer than any word takes from acceptance to its result strobe.
  localparam int DRAIN_CYCLES  = 24;

  // Opcodes that stop the machine, and the opcodes that leave pc advancing.
  localparam logic [3:0] HALT_OPS [4] = '{4'h0, 4'hC, 4'hE, 4'hF};
  localparam logic [3:0] PLAIN_OPS [10] = '{
    OP_LOAD, OP_LDI, OP_STORE, OP_MOVE, OP_ADD, OP_NOP, OP_OR, OP_AND, OP_XOR, OP_ROR
  };

  typedef struct {
    in_word_t word;
    int       gap_after;
  } pending_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;

  // Predicted machine state, updated as each word is accepted.
  logic [7:0] mem_image [MEM_DEPTH];
  logic [7:0] reg_image [REG_COUNT];
  logic [7:0] pc_now;
  logic       halted_now;
  logic       faulted_now;

  pending_t    pending_words [$];
  out_word_t   expected_results [$];
  logic [15:0] program_words [$];
  out_word_t   oldest;
  int          mismatch_count = 0;
  int          items_queued = 0;
  int          idle_left = 0;
  logic        word_taken = 1'b0;
  logic        calm_stretch = 1'b0;

  toy_byte_cpu_step #(
    .MEM_DEPTH(MEM_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The run is cut short if the machine stops answering.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [7:0] mem_byte(input int addr);
    return (addr < MEM_DEPTH) ? mem_image[8'(addr)] : 8'h00;
  endfunction

  // Applies one accepted word to the predicted state and returns the result
  // word that the machine must produce for it.
  function automatic out_word_t machine_step(input in_word_t w);
    out_word_t   res;
    logic [15:0] fetched;
    logic [3:0]  op, rn, sn, tn;
    logic [7:0]  xy, rv;
    int          next_pc;
    bit          jumped;
    res = '0;
    fetched = '0;
    jumped = 1'b0;
    case (w.kind)
      KIND_WRITE: begin
        if (int'(w.address) < MEM_DEPTH) mem_image[w.address] = w.data;
      end
      KIND_RDMEM: res.read_data = mem_byte(int'(w.address));
      KIND_RDREG: res.read_data = reg_image[w.address[3:0]];
      default: begin
        // Executing while halted leaves everything as it is.
        if (!halted_now) begin
          if (int'(pc_now) >= MEM_DEPTH) begin
            halted_now = 1'b1;
            faulted_now = 1'b1;
          end else begin
            // The second byte of a fetch at the last address reads as zero.
            fetched = {mem_byte(int'(pc_now)), mem_byte(int'(pc_now) + 1)};
            next_pc = int'(pc_now) + 2;
            {op, rn, sn, tn} = fetched;
            xy = fetched[7:0];
            case (op)
              OP_LOAD:  reg_image[rn] = mem_byte(int'(xy));
              OP_LDI:   reg_image[rn] = xy;
              OP_STORE: begin
                if (int'(xy) < MEM_DEPTH) mem_image[xy] = reg_image[rn];
              end
              OP_MOVE:  reg_image[tn] = reg_image[sn];
              OP_ADD:   reg_image[rn] = reg_image[sn] + reg_image[tn];
              OP_NOP:   ;
              OP_OR:    reg_image[rn] = reg_image[sn] | reg_image[tn];
              OP_AND:   reg_image[rn] = reg_image[sn] & reg_image[tn];
              OP_XOR:   reg_image[rn] = reg_image[sn] ^ reg_image[tn];
              OP_ROR: begin
                rv = reg_image[rn];
                reg_image[rn] = 8'({rv, rv} >> tn[2:0]);
              end
              OP_JMP: begin
                next_pc = int'(reg_image[rn]);
                jumped = 1'b1;
              end
              OP_BRGT: begin
                if ($signed(reg_image[rn]) > $signed(reg_image[0])) begin
                  next_pc = int'(xy);
                  jumped = 1'b1;
                end
              end
              default: halted_now = 1'b1;
            endcase
            // Falling through past the last address halts with a fault; pc
            // keeps the low byte of the sum.
            if (!jumped && next_pc >= MEM_DEPTH) begin
              halted_now = 1'b1;
              faulted_now = 1'b1;
            end
            pc_now = 8'(next_pc);
          end
        end
      end
    endcase
    res.instruction = fetched;
    res.program_counter = pc_now;
    res.halted = halted_now;
    res.pc_fault = faulted_now;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Driver: at each falling edge it holds a word that has not been taken yet,
  // otherwise it idles for the gap that came with the last word or offers the
  // next pending word.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !word_taken) begin
      start <= 1'b1;
    end else if (idle_left > 0) begin
      start <= 1'b0;
      idle_left <= idle_left - 1;
    end else if (pending_words.size() == 0) begin
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      in_word <= pending_words[0].word;
      idle_left <= pending_words[0].gap_after;
      void'(pending_words.pop_front());
    end
  end

  // Monitor: at each rising edge it checks a result word against the oldest
  // prediction, then predicts the result of a word accepted at this edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      word_taken <= 1'b0;
      foreach (mem_image[i]) mem_image[i] = 8'h00;
      foreach (reg_image[i]) reg_image[i] = 8'h00;
      pc_now = 8'h00;
      halted_now = 1'b0;
      faulted_now = 1'b0;
    end else begin
      word_taken <= start && !busy;
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing expected, pc",
                          32'(out_word.program_counter), 0);
        end else begin
          oldest = expected_results.pop_front();
          if (out_word.read_data !== oldest.read_data)
            report_mismatch("read_data", 32'(out_word.read_data), 32'(oldest.read_data));
          if (out_word.program_counter !== oldest.program_counter)
            report_mismatch("program_counter", 32'(out_word.program_counter),
                            32'(oldest.program_counter));
          if (out_word.instruction !== oldest.instruction)
            report_mismatch("instruction", 32'(out_word.instruction),
                            32'(oldest.instruction));
          if (out_word.halted !== oldest.halted)
            report_mismatch("halted", 32'(out_word.halted), 32'(oldest.halted));
          if (out_word.pc_fault !== oldest.pc_fault)
            report_mismatch("pc_fault", 32'(out_word.pc_fault), 32'(oldest.pc_fault));
        end
      end
      if (start && !busy) expected_results.push_back(machine_step(in_word));
    end
  end

  // Idle cycles after a word: mostly none or a few, now and then a long pause.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    else if (roll < 88) return $urandom_range(1, 3);
    else if (roll < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] instr(input logic [3:0] op, input logic [3:0] rn,
                                        input logic [7:0] xy);
    return {op, rn, xy};
  endfunction

  // Any instruction that lets pc advance by two; stores land in the data area.
  function automatic logic [15:0] random_plain_instr();
    logic [3:0] op;
    logic [7:0] xy;
    op = PLAIN_OPS[4'($urandom_range(0, 9))];
    xy = (op == OP_STORE) ? 8'($urandom_range(DATA_BASE, MEM_DEPTH - 1))
                          : 8'($urandom_range(0, 255));
    return instr(op, 4'($urandom_range(0, 15)), xy);
  endfunction

  task automatic push_item(input kind_t kind, input logic [7:0] addr,
                           input logic [7:0] data);
    pending_t p;
    p.word.kind = kind;
    p.word.address = addr;
    p.word.data = data;
    p.gap_after = calm_stretch ? 0 : gap_len();
    pending_words.push_back(p);
    items_queued++;
  endtask

  task automatic push_random_access(input bit with_writes);
    case ($urandom_range(with_writes ? 0 : 1, 2))
      0:       push_item(KIND_WRITE, 8'($urandom), 8'($urandom));
      1:       push_item(KIND_RDMEM, 8'($urandom), 8'($urandom));
      default: push_item(KIND_RDREG, 8'($urandom), 8'($urandom));
    endcase
  endtask

  // The sender stops here until every queued word is taken and every
  // predicted result has come back, so the predicted pc is current.
  task automatic settle();
    while (pending_words.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic add_jump(input logic [7:0] target);
    logic [3:0] rj;
    rj = 4'($urandom_range(0, 15));
    program_words.push_back(instr(OP_LDI, rj, target));
    program_words.push_back(instr(OP_JMP, rj, 8'($urandom)));
  endtask

  // Writes program_words into memory at the current pc, then executes them,
  // with a random read slipped in before some of the executes.
  task automatic run_program(input int read_pct);
    logic [7:0] base;
    base = pc_now;
    foreach (program_words[i]) begin
      push_item(KIND_WRITE, base + 8'(2 * i), program_words[i][15:8]);
      push_item(KIND_WRITE, base + 8'(2 * i + 1), program_words[i][7:0]);
    end
    foreach (program_words[i]) begin
      if ($urandom_range(0, 99) < read_pct) push_random_access(1'b0);
      push_item(KIND_EXEC, 8'($urandom), 8'($urandom));
    end
  endtask

  // One batch of random work: some noise, then a short straight-line program
  // that may end in a jump or a branch. Code that has drifted too high is
  // instead moved back down with a jump.
  task automatic random_batch();
    int n_ops;
    int ending;
    settle();
    calm_stretch = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(0, 4)) push_random_access(1'b1);
    program_words.delete();
    if (int'(pc_now) > PC_SAFE) begin
      add_jump(8'($urandom_range(0, PC_SAFE)));
    end else begin
      n_ops = $urandom_range(1, 8);
      repeat (n_ops) program_words.push_back(random_plain_instr());
      ending = $urandom_range(0, 3);
      if (ending == 1)
        add_jump(8'($urandom_range(0, PC_SAFE)));
      else if (ending == 2)
        program_words.push_back(instr(OP_BRGT, 4'($urandom_range(0, 15)),
                                      8'($urandom_range(0, PC_SAFE))));
    end
    run_program(30);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: reads of cleared state, the extreme addresses and data,
    // and a program whose operands sit at the signed and unsigned limits.
    push_item(KIND_RDREG, 8'hFF, 8'h00);
    push_item(KIND_RDMEM, 8'h00, 8'hFF);
    push_item(KIND_WRITE, 8'hFF, 8'hFF);
    program_words.push_back(instr(OP_LDI, 4'd1, 8'h7F));
    program_words.push_back(instr(OP_LDI, 4'd2, 8'h80));
    program_words.push_back(instr(OP_ADD, 4'd3, {4'd1, 4'd2}));
    program_words.push_back(instr(OP_ROR, 4'd2, 8'h07));
    program_words.push_back(instr(OP_LOAD, 4'd5, 8'hFF));
    program_words.push_back(instr(OP_STORE, 4'd3, 8'hF0));
    program_words.push_back(instr(OP_MOVE, 4'd0, {4'd5, 4'd6}));
    // R1 = 0x7F is greater than R0 = 0 as signed bytes, so the branch is taken.
    program_words.push_back(instr(OP_BRGT, 4'd1, 8'h40));
    run_program(0);

    while (items_queued < ITEM_TARGET) random_batch();

    // The halt is sticky, so it comes last: a jump to the last address, where
    // a halting opcode is fetched with a zero second byte and pc runs off the
    // end. After that, executes do nothing while memory access still works.
    settle();
    calm_stretch = 1'b0;
    push_item(KIND_WRITE, 8'hFF, {HALT_OPS[2'($urandom_range(0, 3))], 4'($urandom)});
    program_words.delete();
    add_jump(8'hFF);
    run_program(0);
    repeat (3) push_item(KIND_EXEC, 8'($urandom), 8'($urandom));
    push_item(KIND_WRITE, 8'h10, 8'($urandom));
    push_item(KIND_RDMEM, 8'h10, 8'($urandom));
    push_item(KIND_RDMEM, 8'hFF, 8'($urandom));
    push_item(KIND_RDREG, 8'($urandom), 8'($urandom));
    push_item(KIND_EXEC, 8'($urandom), 8'($urandom));

    settle();
    // Any stray result strobe would show up within these cycles.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
